>>> rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CELL_W = 16;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [3:0] RESET_FORE   = 4'd7;
    localparam logic [3:0] RESET_BACK   = 4'd0;

    localparam logic [CELL_W-1:0] RESET_CELL = {RESET_BACK, RESET_FORE, SPACE_CODE};

    localparam logic [1:0] MODE_PUT  = 2'd0;
    localparam logic [1:0] MODE_SET  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic REG_FORE = 1'b0;
    localparam logic REG_BACK = 1'b1;

    typedef struct packed {
        logic [3:0] fore;
        logic [3:0] back;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_BLANK
    } state_t;

endpackage

>>> rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tcw_engine.sv
// ----------------------------------------------------------------------------
// tcw_engine
// Sequencer for the console: cursor and scroll offset, screen memory
// accesses, clearing and row blanking sweeps, and the result register.
// ----------------------------------------------------------------------------
module tcw_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int CW      = $clog2(COLUMNS),
    parameter int RW      = $clog2(ROWS)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tcw_pkg::cfg_t           cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              mode,
    input  logic [7:0]              char_code,
    input  logic [6:0]              column,
    input  logic [4:0]              row,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              cell_char,
    output logic [3:0]              cell_fore,
    output logic [3:0]              cell_back,
    output logic [6:0]              cursor_column,
    output logic [4:0]              cursor_row,
    output logic                    scrolled,
    output logic                    ram_we,
    output logic [RW+CW-1:0]        ram_waddr,
    output logic [tcw_pkg::CELL_W-1:0] ram_wdata,
    output logic [RW+CW-1:0]        ram_raddr,
    input  logic [tcw_pkg::CELL_W-1:0] ram_rdata
);

    import tcw_pkg::*;

    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    state_t            state_reg, state_next;
    logic [CW-1:0]     cur_col_reg, cur_col_next;
    logic [RW-1:0]     cur_row_reg, cur_row_next;
    logic [RW-1:0]     top_reg, top_next;
    logic [CW-1:0]     sweep_col_reg, sweep_col_next;
    logic [RW-1:0]     sweep_row_reg, sweep_row_next;
    logic [CELL_W-1:0] blank_cell_reg, blank_cell_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        cell_char_reg, cell_char_next;
    logic [3:0]        cell_fore_reg, cell_fore_next;
    logic [3:0]        cell_back_reg, cell_back_next;
    logic [6:0]        cursor_column_reg, cursor_column_next;
    logic [4:0]        cursor_row_reg, cursor_row_next;
    logic              scrolled_reg, scrolled_next;

    logic              accept;
    logic [CW-1:0]     col_clamped;
    logic [RW-1:0]     row_clamped;
    logic [5:0]        row_ext;

    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                               input logic [RW-1:0] r);
        logic [RW:0] sum;
        sum = {1'b0, top} + {1'b0, r};
        if (sum >= (RW+1)'(ROWS))
        begin
            sum = sum - (RW+1)'(ROWS);
        end
        return sum[RW-1:0];
    endfunction

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign row_ext     = 6'(row);
    assign col_clamped = ({1'b0, column} >= 8'(COLUMNS)) ? LAST_COL : column[CW-1:0];
    assign row_clamped = ({2'b0, row} >= 7'(ROWS)) ? LAST_ROW : row_ext[RW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            top_reg       <= '0;
            sweep_col_reg <= '0;
            sweep_row_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            top_reg       <= top_next;
            sweep_col_reg <= sweep_col_next;
            sweep_row_reg <= sweep_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blank_cell_reg    <= blank_cell_next;
        cell_char_reg     <= cell_char_next;
        cell_fore_reg     <= cell_fore_next;
        cell_back_reg     <= cell_back_next;
        cursor_column_reg <= cursor_column_next;
        cursor_row_reg    <= cursor_row_next;
        scrolled_reg      <= scrolled_next;
    end

    always_comb
    begin
        logic wrap;
        state_next         = state_reg;
        cur_col_next       = cur_col_reg;
        cur_row_next       = cur_row_reg;
        top_next           = top_reg;
        sweep_col_next     = sweep_col_reg;
        sweep_row_next     = sweep_row_reg;
        blank_cell_next    = blank_cell_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        cell_char_next     = cell_char_reg;
        cell_fore_next     = cell_fore_reg;
        cell_back_next     = cell_back_reg;
        cursor_column_next = cursor_column_reg;
        cursor_row_next    = cursor_row_reg;
        scrolled_next      = scrolled_reg;
        ram_we             = 1'b0;
        ram_waddr          = '0;
        ram_wdata          = '0;
        ram_raddr          = {phys_row(top_reg, row_clamped), col_clamped};
        wrap               = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = {sweep_row_reg, sweep_col_reg};
                ram_wdata = RESET_CELL;
                if (sweep_col_reg == LAST_COL)
                begin
                    sweep_col_next = '0;
                    if (sweep_row_reg == LAST_ROW)
                    begin
                        sweep_row_next = '0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        sweep_row_next = sweep_row_reg + 1'b1;
                    end
                end
                else
                begin
                    sweep_col_next = sweep_col_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    cell_char_next = '0;
                    cell_fore_next = '0;
                    cell_back_next = '0;
                    scrolled_next  = 1'b0;
                    out_valid_next = 1'b1;
                    case (mode)
                        MODE_PUT:
                        begin
                            if (char_code == NEWLINE_CODE)
                            begin
                                wrap = 1'b1;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = {phys_row(top_reg, cur_row_reg), cur_col_reg};
                                ram_wdata = {cfg.back, cfg.fore, char_code};
                                wrap      = (cur_col_reg == LAST_COL);
                            end
                            if (wrap)
                            begin
                                cur_col_next = '0;
                                if (cur_row_reg == LAST_ROW)
                                begin
                                    // The old top row becomes the new bottom row.
                                    top_next        = (top_reg == LAST_ROW) ? '0
                                                                            : top_reg + 1'b1;
                                    sweep_row_next  = top_reg;
                                    sweep_col_next  = '0;
                                    blank_cell_next = {cfg.back, cfg.fore, SPACE_CODE};
                                    scrolled_next   = 1'b1;
                                    state_next      = ST_BLANK;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + 1'b1;
                            end
                        end
                        MODE_SET:
                        begin
                            cur_col_next = col_clamped;
                            cur_row_next = row_clamped;
                        end
                        MODE_READ:
                        begin
                            out_valid_next = 1'b0;
                            state_next     = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                    cursor_column_next = 7'(cur_col_next);
                    cursor_row_next    = 5'(cur_row_next);
                end
            end

            ST_READ:
            begin
                out_valid_next = 1'b1;
                cell_char_next = ram_rdata[7:0];
                cell_fore_next = ram_rdata[11:8];
                cell_back_next = ram_rdata[15:12];
                state_next     = ST_IDLE;
            end

            ST_BLANK:
            begin
                ram_we    = 1'b1;
                ram_waddr = {sweep_row_reg, sweep_col_reg};
                ram_wdata = blank_cell_reg;
                if (sweep_col_reg == LAST_COL)
                begin
                    sweep_col_next = '0;
                    sweep_row_next = '0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    sweep_col_next = sweep_col_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign cell_char     = cell_char_reg;
    assign cell_fore     = cell_fore_reg;
    assign cell_back     = cell_back_reg;
    assign cursor_column = cursor_column_reg;
    assign cursor_row    = cursor_row_reg;
    assign scrolled      = scrolled_reg;

endmodule

>>> rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console with a linear cursor and scroll-up.
// ----------------------------------------------------------------------------
// Items arrive on the input channel (in_valid/in_ready) as one beat each:
// mode 0 puts a character or newline, mode 1 sets the cursor, mode 2 reads
// a cell. Every item returns one beat on the output channel
// (out_valid/out_ready) with the cell contents for a read and the cursor.
// Colors are set through the APB port: foreground at 0x0, background at 0x4.
// A put, set or ignored item gives its result in the cycle after acceptance;
// unless it scrolls, the next item can be taken in the following cycle, one
// item per cycle while out_ready is high. A read passes through the READ
// state, which loads the registered screen-memory read into the result. A
// scroll moves a top-row offset and then blanks one memory row, so the input
// is held off while that row is blanked. After reset the screen memory is
// swept to spaces with foreground 7 and background 0, one cell per cycle,
// over all ROWS*COLUMNS cells; no item is accepted until the sweep ends.
// While a result waits on the output, one more item may be accepted only in
// the cycle in which that result is taken.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  char_code,
    input  logic [6:0]  column,
    input  logic [4:0]  row,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  cell_char,
    output logic [3:0]  cell_fore,
    output logic [3:0]  cell_back,
    output logic [6:0]  cursor_column,
    output logic [4:0]  cursor_row,
    output logic        scrolled
);

    import tcw_pkg::*;

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int DEPTH = ROWS * (2 ** CW);

    cfg_t              cfg_reg;
    logic              cfg_write;
    logic              ram_we;
    logic [RW+CW-1:0]  ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [RW+CW-1:0]  ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fore <= RESET_FORE;
            cfg_reg.back <= RESET_BACK;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_FORE: cfg_reg.fore <= pwdata[3:0];
                REG_BACK: cfg_reg.back <= pwdata[3:0];
                default:  cfg_reg      <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FORE: prdata = 32'(cfg_reg.fore);
            REG_BACK: prdata = 32'(cfg_reg.back);
            default:  prdata = '0;
        endcase
    end

    tcw_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CW      (CW),
        .RW      (RW)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .char_code     (char_code),
        .column        (column),
        .row           (row),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cell_char     (cell_char),
        .cell_fore     (cell_fore),
        .cell_back     (cell_back),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .scrolled      (scrolled),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

>>> bench/text_console_writer_test.sv
// ----------------------------------------------------------------------------
// text_console_writer_test
// Self-checking testbench for the text console writer.
// ----------------------------------------------------------------------------
// A table of directed items probes the cleared screen, the extreme character
// codes, saturating coordinates, the ignored mode, and scrolling by a
// character and by a newline on the bottom row. Random phases follow, each
// with its own colors set over APB. Every result beat is compared field by
// field with the table's expected beat or an in-order prediction of the
// screen and cursor, while both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module text_console_writer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLS   = DEF_COLUMNS;
    localparam int LINES  = DEF_ROWS;
    localparam int CELLS  = COLS * LINES;
    localparam int SETTLE = 2 * COLS + 16;
    localparam int PHASES = 5;
    localparam int PHASE_ITEMS  = 370;
    localparam int PRESSURE_AT  = 400;
    localparam int PRESSURE_LEN = 300;
    localparam int PROBE_COUNT  = 25;

    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam logic [2:0] ADDR_FORE = {REG_FORE, 2'b00};
    localparam logic [2:0] ADDR_BACK = {REG_BACK, 2'b00};

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] ch;
        logic [6:0] col;
        logic [4:0] row;
    } console_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic [3:0] fore;
        logic [3:0] back;
        logic [6:0] cur_col;
        logic [4:0] cur_row;
        logic       scrolled;
    } console_result_t;

    typedef struct packed {
        console_item_t   item;
        logic            known;
        console_result_t want;
    } probe_t;

    localparam probe_t PROBES [PROBE_COUNT] = '{
        '{'{MODE_READ, 8'h00, 7'd0, 5'd0}, 1'b1, '{8'h20, 4'd7, 4'd0, 7'd0, 5'd0, 1'b0}},
        '{'{MODE_READ, 8'h00, 7'd127, 5'd31}, 1'b1, '{8'h20, 4'd7, 4'd0, 7'd0, 5'd0, 1'b0}},
        '{'{MODE_PUT, 8'h41, 7'd0, 5'd0}, 1'b1, '{8'h00, 4'd0, 4'd0, 7'd1, 5'd0, 1'b0}},
        '{'{MODE_READ, 8'h00, 7'd0, 5'd0}, 1'b1, '{8'h41, 4'd7, 4'd0, 7'd1, 5'd0, 1'b0}},
        '{'{MODE_PUT, 8'hFF, 7'd127, 5'd31}, 1'b1, '{8'h00, 4'd0, 4'd0, 7'd2, 5'd0, 1'b0}},
        '{'{MODE_PUT, 8'h00, 7'd0, 5'd0}, 1'b1, '{8'h00, 4'd0, 4'd0, 7'd3, 5'd0, 1'b0}},
        '{'{MODE_PUT, NEWLINE_CODE, 7'd0, 5'd0}, 1'b1,
          '{8'h00, 4'd0, 4'd0, 7'd0, 5'd1, 1'b0}},
        '{'{MODE_IGNORED, 8'hFF, 7'd127, 5'd31}, 1'b1,
          '{8'h00, 4'd0, 4'd0, 7'd0, 5'd1, 1'b0}},
        '{'{MODE_READ, 8'h00, 7'd1, 5'd0}, 1'b1, '{8'hFF, 4'd7, 4'd0, 7'd0, 5'd1, 1'b0}},
        '{'{MODE_SET, 8'h00, 7'd127, 5'd31}, 1'b1, '{8'h00, 4'd0, 4'd0, 7'd79, 5'd24, 1'b0}},
        '{'{MODE_PUT, 8'h5A, 7'd0, 5'd0}, 1'b1, '{8'h00, 4'd0, 4'd0, 7'd0, 5'd24, 1'b1}},
        '{'{MODE_READ, 8'h00, 7'd79, 5'd23}, 1'b1, '{8'h5A, 4'd7, 4'd0, 7'd0, 5'd24, 1'b0}},
        '{'{MODE_READ, 8'h00, 7'd0, 5'd24}, 1'b1, '{8'h20, 4'd7, 4'd0, 7'd0, 5'd24, 1'b0}},
        '{'{MODE_PUT, NEWLINE_CODE, 7'd0, 5'd0}, 1'b1,
          '{8'h00, 4'd0, 4'd0, 7'd0, 5'd24, 1'b1}},
        '{'{MODE_READ, 8'h00, 7'd79, 5'd22}, 1'b1, '{8'h5A, 4'd7, 4'd0, 7'd0, 5'd24, 1'b0}},
        '{'{MODE_SET, 8'h00, 7'd80, 5'd25}, 1'b1, '{8'h00, 4'd0, 4'd0, 7'd79, 5'd24, 1'b0}},
        '{'{MODE_PUT, NEWLINE_CODE, 7'd0, 5'd0}, 1'b1,
          '{8'h00, 4'd0, 4'd0, 7'd0, 5'd24, 1'b1}},
        '{'{MODE_SET, 8'h00, 7'd0, 5'd0}, 1'b1, '{8'h00, 4'd0, 4'd0, 7'd0, 5'd0, 1'b0}},
        '{'{MODE_READ, 8'h00, 7'd0, 5'd0}, 1'b0, '0},
        '{'{MODE_SET, 8'h00, 7'd40, 5'd12}, 1'b0, '0},
        '{'{MODE_PUT, 8'h7F, 7'd0, 5'd0}, 1'b0, '0},
        '{'{MODE_READ, 8'h00, 7'd40, 5'd12}, 1'b0, '0},
        '{'{MODE_SET, 8'h00, 7'd127, 5'd0}, 1'b0, '0},
        '{'{MODE_PUT, 8'h55, 7'd0, 5'd0}, 1'b0, '0},
        '{'{MODE_READ, 8'h00, 7'd79, 5'd0}, 1'b0, '0}
    };

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [7:0]  char_code;
    logic [6:0]  column;
    logic [4:0]  row;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  cell_char;
    logic [3:0]  cell_fore;
    logic [3:0]  cell_back;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic        scrolled;

    logic [CELL_W-1:0] screen_model [CELLS];
    int unsigned       cursor_model;
    logic [3:0]        text_fore;
    logic [3:0]        text_back;

    console_result_t pending_results [$];
    int errors;
    int items_sent;
    int results_seen;
    int scroll_count;
    int read_count;
    int color_writes;
    bit idle_on;
    bit pressure_done;
    int stall_left;

    text_console_writer dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .char_code(char_code),
        .column(column),
        .row(row),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cell_char(cell_char),
        .cell_fore(cell_fore),
        .cell_back(cell_back),
        .cursor_column(cursor_column),
        .cursor_row(cursor_row),
        .scrolled(scrolled)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("Timeout at %0t with %0d results outstanding", $time,
                 pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned cell_index(logic [6:0] col, logic [4:0] rw);
        int unsigned c;
        int unsigned r;
        c = (col >= COLS) ? COLS - 1 : col;
        r = (rw >= LINES) ? LINES - 1 : rw;
        return r * COLS + c;
    endfunction

    // Advances the screen and cursor by one item and returns its result beat.
    function automatic console_result_t apply_console_item(console_item_t it);
        console_result_t res;
        logic [CELL_W-1:0] cell_word;
        res = '0;
        case (it.mode)
            MODE_PUT:
            begin
                if (it.ch == NEWLINE_CODE)
                    cursor_model = (cursor_model / COLS + 1) * COLS;
                else
                begin
                    screen_model[cursor_model] = {text_back, text_fore, it.ch};
                    cursor_model++;
                end
                if (cursor_model >= CELLS)
                begin
                    for (int i = 0; i < CELLS - COLS; i++)
                        screen_model[i] = screen_model[i + COLS];
                    for (int i = CELLS - COLS; i < CELLS; i++)
                        screen_model[i] = {text_back, text_fore, SPACE_CODE};
                    cursor_model = CELLS - COLS;
                    res.scrolled = 1'b1;
                    scroll_count++;
                end
            end
            MODE_SET:
                cursor_model = cell_index(it.col, it.row);
            MODE_READ:
            begin
                cell_word = screen_model[cell_index(it.col, it.row)];
                res.ch = cell_word[7:0];
                res.fore = cell_word[11:8];
                res.back = cell_word[15:12];
                read_count++;
            end
            default:
                ;
        endcase
        res.cur_col = 7'(cursor_model % COLS);
        res.cur_row = 5'(cursor_model / COLS);
        return res;
    endfunction

    function automatic logic [4:0] random_coord_row();
        case ($urandom_range(0, 5))
            0, 1, 2: return 5'($urandom_range(LINES - 5, LINES - 1));
            3, 4: return 5'($urandom_range(0, LINES - 1));
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic console_item_t random_console_item();
        console_item_t it;
        int unsigned pick;
        it.ch = 8'($urandom_range(0, 255));
        it.col = 7'($urandom_range(0, 127));
        it.row = 5'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            it.mode = MODE_PUT;
            if ($urandom_range(0, 7) == 0)
                it.ch = NEWLINE_CODE;
        end
        else if (pick < 95)
        begin
            it.mode = (pick < 70) ? MODE_SET : MODE_READ;
            if ($urandom_range(0, 6) != 0)
                it.col = 7'($urandom_range(0, COLS - 1));
            it.row = random_coord_row();
        end
        else
            it.mode = MODE_IGNORED;
        return it;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic send_item(console_item_t it, logic known, console_result_t want);
        console_result_t predicted;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= it.mode;
        char_code <= it.ch;
        column <= it.col;
        row <= it.row;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = apply_console_item(it);
        pending_results.push_back(known ? want : predicted);
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_color(logic [2:0] addr, logic [3:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {28'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        if (addr == ADDR_FORE)
            text_fore = value;
        else
            text_back = value;
        color_writes++;
    endtask

    // Result side: checks every beat and stalls in random bursts, plus one
    // long hold so that the input side backs up.
    initial
    begin
        console_result_t want;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result beat with no item outstanding", $time);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("cell_char", want.ch, cell_char);
                    check_field("cell_fore", 8'(want.fore), 8'(cell_fore));
                    check_field("cell_back", 8'(want.back), 8'(cell_back));
                    check_field("cursor_column", 8'(want.cur_col), 8'(cursor_column));
                    check_field("cursor_row", 8'(want.cur_row), 8'(cursor_row));
                    check_field("scrolled", 8'(want.scrolled), 8'(scrolled));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!pressure_done && results_seen >= PRESSURE_AT)
            begin
                pressure_done = 1'b1;
                stall_left = PRESSURE_LEN - 1;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        logic [3:0] fore_plan [PHASES];
        logic [3:0] back_plan [PHASES];
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        mode <= MODE_PUT;
        char_code <= '0;
        column <= '0;
        row <= '0;
        idle_on = 1'b1;
        fore_plan = '{4'd15, 4'd0, 4'd15, 4'd0, 4'($urandom_range(0, 15))};
        back_plan = '{4'd15, 4'd0, 4'd0, 4'd15, 4'($urandom_range(0, 15))};
        text_fore = RESET_FORE;
        text_back = RESET_BACK;
        cursor_model = 0;
        for (int i = 0; i < CELLS; i++)
            screen_model[i] = RESET_CELL;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PROBE_COUNT; i++)
            send_item(PROBES[i].item, PROBES[i].known, PROBES[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            write_color(ADDR_FORE, fore_plan[p]);
            write_color(ADDR_BACK, back_plan[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == PHASES - 1)
                    idle_on = 1'b0;
                else if (n % 100 == 0)
                    idle_on = ($urandom_range(0, 3) != 0);
                send_item(random_console_item(), 1'b0, '0);
            end
        end
        drain_results();

        $display("Sent %0d items (%0d directed) across %0d color settings.",
                 items_sent, PROBE_COUNT, PHASES + 1);
        $display("Saw %0d scrolls and %0d cell reads; %0d color writes.",
                 scroll_count, read_count, color_writes);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
